// ===== hdl/text_cell_glyph_row_generator_core_defines.svh =====
// Assertion helpers used by the top-level core file.
`ifndef TEXT_CELL_GLYPH_ROW_GENERATOR_CORE_DEFINES_SVH
`define TEXT_CELL_GLYPH_ROW_GENERATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/tcg_pkg.sv =====
package tcg_pkg;

  localparam int GlyphStoreDepthDef = 8192;

  localparam int StoreAddrW = 13;
  localparam int ByteW      = 8;
  localparam int RowW       = 4;
  localparam int ColorW     = 3;

  // Action codes carried in tuser.
  localparam logic ActWrite  = 1'b0;
  localparam logic ActRender = 1'b1;

  // Configuration register indexes.
  localparam logic CfgDisplayMode = 1'b0;
  localparam logic CfgPcgEnable   = 1'b1;

  localparam logic [StoreAddrW-1:0] GraphicBank = 13'd2048;
  localparam logic [StoreAddrW-1:0] PcgBank     = 13'd4096;

  localparam logic [RowW-1:0] LastRowTall  = 4'd9;
  localparam logic [RowW-1:0] LastRowShort = 4'd7;

  // Attribute bits.
  localparam int AttrUpper   = 3;
  localparam int AttrGraphic = 4;
  localparam int AttrReverse = 5;
  localparam int AttrSecret  = 6;
  localparam int AttrUnder   = 7;

  typedef struct packed {
    logic [StoreAddrW-1:0] addr;
    logic [RowW-1:0]       row;
    logic                  last;
    logic                  blank;
    logic                  wide;
    logic [ByteW-1:0]      attr;
  } row_req_t;

endpackage

// ===== hdl/tcg_seq.sv =====
module tcg_seq import tcg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ByteW-1:0] char_code_i,
  input  logic [ByteW-1:0] attr_i,
  input  logic [1:0]       display_mode_i,
  input  logic             pcg_enable_i,
  input  logic             adv_i,
  output logic             ready_o,
  output logic             req_vld_o,
  output row_req_t         req_o
);

  logic                  vld_q, vld_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [StoreAddrW-1:0] base_q, base_d;
  logic [ByteW-1:0]      attr_q;
  logic                  tall_q, wide_q;
  logic                  last;
  logic [2:0]            glyph_row;

  assign last    = row_q == (tall_q ? LastRowTall : LastRowShort);
  assign ready_o = !vld_q || (last && adv_i);

  always_comb begin
    base_d = {2'b00, char_code_i, 3'b000};
    if (attr_i[AttrGraphic]) begin
      base_d = base_d + GraphicBank;
    end else if (pcg_enable_i) begin
      base_d = base_d + PcgBank;
    end
  end

  always_comb begin
    vld_d = vld_q;
    row_d = row_q;
    if (start_i) begin
      vld_d = 1'b1;
      row_d = '0;
    end else if (vld_q && adv_i) begin
      if (last) begin
        vld_d = 1'b0;
      end else begin
        row_d = row_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      row_q <= '0;
    end else begin
      vld_q <= vld_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      base_q <= base_d;
      attr_q <= attr_i;
      tall_q <= !display_mode_i[0];
      wide_q <= display_mode_i[1];
    end
  end

  // Tall cells have a blank top row, so glyph rows lag the cell row by one.
  assign glyph_row = tall_q ? 3'(row_q - 4'd1) : row_q[2:0];

  assign req_vld_o   = vld_q;
  assign req_o.addr  = base_q + {10'd0, glyph_row};
  assign req_o.row   = row_q;
  assign req_o.last  = last;
  assign req_o.blank = tall_q && (row_q == '0 || last);
  assign req_o.wide  = wide_q;
  assign req_o.attr  = attr_q;

endmodule

// ===== hdl/tcg_glyph_mem.sv =====
module tcg_glyph_mem import tcg_pkg::*; #(
  parameter int Depth = GlyphStoreDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [StoreAddrW-1:0] wr_addr_i,
  input  logic [ByteW-1:0]      wr_data_i,
  input  logic                  adv_i,
  input  logic                  req_vld_i,
  input  row_req_t              req_i,
  output logic                  rd_vld_o,
  output row_req_t              rd_req_o,
  output logic [ByteW-1:0]      rd_data_o
);

  localparam int AddrW = $clog2(Depth);

  logic [ByteW-1:0] mem_q [Depth];
  logic             rd_vld_q;
  row_req_t         rd_req_q;
  logic [ByteW-1:0] rd_data_q;

  // Writes past the store depth are dropped.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_addr_i) < Depth)) begin
      mem_q[wr_addr_i[AddrW-1:0]] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rd_data_q <= mem_q[req_i.addr[AddrW-1:0]];
      rd_req_q  <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (adv_i) begin
      rd_vld_q <= req_vld_i;
    end
  end

  assign rd_vld_o  = rd_vld_q;
  assign rd_req_o  = rd_req_q;
  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/tcg_shade.sv =====
module tcg_shade import tcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  row_req_t          req_i,
  input  logic [ByteW-1:0]  data_i,
  input  logic              out_ready_i,
  output logic              adv_o,
  output logic              out_vld_o,
  output logic [ByteW-1:0]  pixel_row_o,
  output logic [RowW-1:0]   row_index_o,
  output logic [ColorW-1:0] color_index_o,
  output logic              last_row_o
);

  logic              out_vld_q;
  logic [ByteW-1:0]  pixel_q, pixel_d;
  logic [RowW-1:0]   row_q;
  logic [ColorW-1:0] color_q;
  logic              last_q;

  assign adv_o = !out_vld_q || out_ready_i;

  always_comb begin
    pixel_d = req_i.blank ? '0 : data_i;
    if (req_i.attr[AttrSecret]) begin
      pixel_d = '0;
    end
    if (req_i.attr[AttrUnder] && req_i.last) begin
      pixel_d = '1;
    end
    if (req_i.attr[AttrUpper] && req_i.row == '0) begin
      pixel_d = '1;
    end
    if (req_i.attr[AttrReverse]) begin
      pixel_d = ~pixel_d;
    end
    // Narrow columns keep four pixels, each the OR of a pixel pair.
    if (req_i.wide) begin
      pixel_d = {pixel_d[7] | pixel_d[6], pixel_d[5] | pixel_d[4],
                 pixel_d[3] | pixel_d[2], pixel_d[1] | pixel_d[0], 4'b0000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      out_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      pixel_q <= pixel_d;
      row_q   <= req_i.row;
      color_q <= req_i.attr[ColorW-1:0];
      last_q  <= req_i.last;
    end
  end

  assign out_vld_o     = out_vld_q;
  assign pixel_row_o   = pixel_q;
  assign row_index_o   = row_q;
  assign color_index_o = color_q;
  assign last_row_o    = last_q;

endmodule

// ===== hdl/text_cell_glyph_row_generator_core.sv =====
// Text-mode character generator core.
//
// The input stream carries two kinds of request, chosen by tuser. A write
// request stores one glyph byte and yields no output. A render request
// carries a character code and an attribute byte and yields the pixel
// rows of that cell on the output stream, one row per beat, with tlast on
// the final row: 10 rows in the 20-line layouts, 8 in the 25-line ones.
// Layout and programmable bank selection come from two configuration port
// registers, written by the user only while idle; the core does not check.
//
// Throughput: one output row per cycle while tready is high; a render
// request holds the input until its last row is issued. The row sequencer
// issues one row per cycle unless stalled; the store takes one write per
// cycle while no cell is being issued. Rows pass the row sequencer, store
// read and attribute stage, each registered. The input accepts the next
// request in the same cycle the previous cell issues its last row.
//
// Reset clears the pipeline and the registers; glyph store contents are
// undefined until written. While tready is low and a row waits on the
// output, every stage holds its row, so nothing is dropped or repeated.
`include "text_cell_glyph_row_generator_core_defines.svh"

module text_cell_glyph_row_generator_core import tcg_pkg::*; #(
  parameter int GLYPH_STORE_DEPTH = GlyphStoreDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // store_address[12:0], store_data[20:13], char_code[28:21],
  // cell_attribute[36:29], zero fill [39:37]
  input  logic [39:0] s_axis_tdata,
  // action[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_row[7:0], row_index[11:8], color_index[14:12], zero fill [15]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [1:0]            display_mode_q;
  logic                  pcg_enable_q;
  logic                  in_take;
  logic                  start;
  logic                  wr_en;
  logic                  adv;
  logic                  req_vld;
  row_req_t              req;
  logic                  rd_vld;
  row_req_t              rd_req;
  logic [ByteW-1:0]      rd_data;
  logic [ByteW-1:0]      pixel_row;
  logic [RowW-1:0]       row_index;
  logic [ColorW-1:0]     color_index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_mode_q <= '0;
      pcg_enable_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgDisplayMode: display_mode_q <= cfg_wdata_i;
        CfgPcgEnable:   pcg_enable_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_take = s_axis_tvalid && s_axis_tready;
  assign start   = in_take && (s_axis_tuser[0] == ActRender);
  assign wr_en   = in_take && (s_axis_tuser[0] == ActWrite);

  tcg_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .char_code_i    (s_axis_tdata[28:21]),
    .attr_i         (s_axis_tdata[36:29]),
    .display_mode_i (display_mode_q),
    .pcg_enable_i   (pcg_enable_q),
    .adv_i          (adv),
    .ready_o        (s_axis_tready),
    .req_vld_o      (req_vld),
    .req_o          (req)
  );

  tcg_glyph_mem #(
    .Depth (GLYPH_STORE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (s_axis_tdata[12:0]),
    .wr_data_i (s_axis_tdata[20:13]),
    .adv_i     (adv),
    .req_vld_i (req_vld),
    .req_i     (req),
    .rd_vld_o  (rd_vld),
    .rd_req_o  (rd_req),
    .rd_data_o (rd_data)
  );

  tcg_shade u_shade (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (rd_vld),
    .req_i         (rd_req),
    .data_i        (rd_data),
    .out_ready_i   (m_axis_tready),
    .adv_o         (adv),
    .out_vld_o     (m_axis_tvalid),
    .pixel_row_o   (pixel_row),
    .row_index_o   (row_index),
    .color_index_o (color_index),
    .last_row_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, color_index, row_index, pixel_row};

  // A new cell always starts at its first row.
  `ASSERT_NXT(a_start_row0, clk_i, rst_ni, start, req_vld && req.row == '0)
  // The final row of a cell is row 7 or row 9.
  `ASSERT_IMP(a_last_row, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
              row_index == LastRowShort || row_index == LastRowTall)
  // A stalled read stage keeps its row.
  `ASSERT_NXT(a_read_hold, clk_i, rst_ni, rd_vld && !adv, rd_vld && $stable(rd_req))
  // The input is only held off while a cell is still being issued.
  `ASSERT_IMP(a_ready_busy, clk_i, rst_ni, !s_axis_tready, req_vld && !(req.last && adv))

endmodule

// ===== test/tb_text_cell_glyph_row_generator_core.sv =====
module tb_text_cell_glyph_row_generator_core import tcg_pkg::*;;

  localparam int StoreDepth = GlyphStoreDepthDef;
  localparam int TimeLimit  = 2000000;
  localparam int SettleCycles = 8;
  localparam int PhaseItems = 40;

  localparam logic [1:0] Layout40x20 = 2'd0;
  localparam logic [1:0] Layout40x25 = 2'd1;
  localparam logic [1:0] Layout80x20 = 2'd2;
  localparam logic [1:0] Layout80x25 = 2'd3;

  localparam logic [7:0] UpperMask   = 8'h1 << AttrUpper;
  localparam logic [7:0] GraphicMask = 8'h1 << AttrGraphic;
  localparam logic [7:0] ReverseMask = 8'h1 << AttrReverse;
  localparam logic [7:0] SecretMask  = 8'h1 << AttrSecret;
  localparam logic [7:0] UnderMask   = 8'h1 << AttrUnder;
  localparam logic [7:0] ColorMask   = 8'h07;

  typedef struct packed {
    logic [ByteW-1:0]  pixels;
    logic [RowW-1:0]   row;
    logic [ColorW-1:0] color;
    logic              last;
  } cell_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_addr_i = '0;
  logic [1:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  text_cell_glyph_row_generator_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Shadow of the block: glyph store, which entries hold data, and registers.
  logic [ByteW-1:0] glyph_mem [StoreDepth];
  bit               glyph_written [StoreDepth];
  logic [1:0]       layout_r = Layout40x20;
  logic             pcg_r = 1'b0;

  cell_row_t pending_rows_q [$];

  int  mism_cnt = 0;
  int  item_cnt = 0;
  int  write_cnt = 0;
  int  render_cnt = 0;
  int  rows_checked = 0;
  bit  src_steady = 1'b0;
  bit  snk_steady = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #(TimeLimit);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [ByteW-1:0] squeeze_pairs(logic [ByteW-1:0] b);
    return {b[7] | b[6], b[5] | b[4], b[3] | b[2], b[1] | b[0], 4'b0000};
  endfunction

  function automatic int glyph_base(logic [7:0] code, logic [7:0] attr);
    int base;
    base = int'(code) * 8;
    if ((attr & GraphicMask) != 0) base += int'(GraphicBank);
    else if (pcg_r) base += int'(PcgBank);
    return base;
  endfunction

  function automatic logic [ByteW-1:0] read_glyph(int addr);
    if (addr >= StoreDepth) return '0;
    return glyph_mem[addr];
  endfunction

  // Queue the rows that one render request must produce.
  function automatic void predict_cell(logic [7:0] code, logic [7:0] attr);
    bit        tall;
    int        rows;
    int        base;
    cell_row_t r;
    logic [ByteW-1:0] bits;
    tall = (layout_r[0] == 1'b0);
    rows = tall ? 10 : 8;
    base = glyph_base(code, attr);
    for (int i = 0; i < rows; i++) begin
      if (tall) bits = (i > 0 && i < 9) ? read_glyph(base + i - 1) : '0;
      else bits = read_glyph(base + i);
      if ((attr & SecretMask) != 0) bits = '0;
      if ((attr & UnderMask) != 0 && i == rows - 1) bits = 8'hFF;
      if ((attr & UpperMask) != 0 && i == 0) bits = 8'hFF;
      if ((attr & ReverseMask) != 0) bits = ~bits;
      if (layout_r[1]) bits = squeeze_pairs(bits);
      r.pixels = bits;
      r.row    = RowW'(i);
      r.color  = attr[ColorW-1:0];
      r.last   = (i == rows - 1);
      pending_rows_q.push_back(r);
    end
  endfunction

  task automatic flag_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mism_cnt++;
      if (mism_cnt <= 10) $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // Receiver: random back-pressure unless steady, changed at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= snk_steady || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin
    cell_row_t got;
    cell_row_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tdata[14:12], m_axis_tlast};
      if (pending_rows_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected row: got %h", got);
      end else begin
        want = pending_rows_q.pop_front();
        flag_field("pixel_row", want.pixels, got.pixels);
        flag_field("row_index", 8'(want.row), 8'(got.row));
        flag_field("color_index", 8'(want.color), 8'(got.color));
        flag_field("last_row", 8'(want.last), 8'(got.last));
        rows_checked++;
      end
    end
  end

  // Sends one request; called and returning at a falling edge. The valid
  // stays high on return so that a following request goes back to back.
  task automatic send_item(logic act, logic [12:0] addr, logic [7:0] data,
                           logic [7:0] code, logic [7:0] attr);
    while (!src_steady && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {3'b000, attr, code, data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ActWrite) begin
      glyph_mem[addr] = data;
      glyph_written[addr] = 1'b1;
      write_cnt++;
    end else begin
      predict_cell(code, attr);
      render_cnt++;
    end
    item_cnt++;
    @(negedge clk_i);
  endtask

  // Unused fields carry random filler.
  task automatic send_write(int addr, logic [7:0] data);
    send_item(ActWrite, 13'(addr), data, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic render_cell(logic [7:0] code, logic [7:0] attr);
    int base;
    base = glyph_base(code, attr);
    // Every glyph row of the cell must hold data before it is read.
    for (int g = 0; g < 8; g++) begin
      if (!glyph_written[base + g]) send_write(base + g, 8'($urandom_range(255)));
    end
    send_item(ActRender, 13'($urandom_range(8191)), 8'($urandom_range(255)), code, attr);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_rows_q.size() != 0) @(negedge clk_i);
    // A write request is stored as soon as it is taken and never enters the pipeline.
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    pause_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgDisplayMode) layout_r = val;
    else pcg_r = val[0];
  endtask

  task automatic test_store_edges();
    write_reg(CfgDisplayMode, Layout40x20);
    write_reg(CfgPcgEnable, 2'b00);
    send_write(0, 8'hFF);
    send_write(StoreDepth - 1, 8'h00);
    send_write(StoreDepth - 1, 8'hFF);
    render_cell(8'h00, 8'h00);
  endtask

  task automatic test_attributes();
    logic [7:0] pattern [8];
    pattern = '{8'h80, 8'h01, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h3C, 8'hC3};
    for (int g = 0; g < 8; g++) send_write(255 * 8 + g, pattern[g]);
    render_cell(8'hFF, 8'h00);
    render_cell(8'hFF, ColorMask);
    render_cell(8'hFF, UpperMask);
    render_cell(8'hFF, GraphicMask);
    render_cell(8'hFF, ReverseMask);
    render_cell(8'hFF, SecretMask);
    render_cell(8'hFF, UnderMask);
    render_cell(8'hFF, 8'hFF);
  endtask

  task automatic test_layouts();
    write_reg(CfgDisplayMode, Layout40x25);
    render_cell(8'hFF, UnderMask | UpperMask | 8'h05);
    render_cell(8'hFF, ReverseMask);
    write_reg(CfgDisplayMode, Layout80x20);
    render_cell(8'hFF, UnderMask | UpperMask);
    render_cell(8'hFF, ReverseMask | 8'h02);
    write_reg(CfgDisplayMode, Layout80x25);
    render_cell(8'hFF, UnderMask | UpperMask);
    render_cell(8'hFF, ReverseMask);
  endtask

  task automatic test_pcg_bank();
    write_reg(CfgDisplayMode, Layout40x20);
    write_reg(CfgPcgEnable, 2'b01);
    render_cell(8'h00, 8'h00);
    render_cell(8'hFF, 8'h00);
    // The graphic bit wins over the programmable bank.
    render_cell(8'h00, GraphicMask);
  endtask

  task automatic test_random_traffic();
    int         start;
    logic [1:0] lay;
    logic [7:0] code;
    bit         paused;
    start = item_cnt;
    paused = 1'b0;
    for (int p = 0; p < 6; p++) begin
      lay = 2'((p * 3) % 4);
      write_reg(CfgDisplayMode, lay);
      write_reg(CfgPcgEnable, 2'((p % 3) == 1));
      src_steady = (p == 2);
      snk_steady = (p == 2);
      while (item_cnt - start < (p + 1) * PhaseItems) begin
        if (p == 4 && !paused && item_cnt - start >= 4 * PhaseItems + PhaseItems / 2) begin
          paused = 1'b1;
          pause_until_drained();
        end
        if ($urandom_range(99) < 20) begin
          send_write($urandom_range(StoreDepth - 1), 8'($urandom_range(255)));
        end else begin
          // Reusing a few codes keeps most renders on glyphs already loaded.
          if ($urandom_range(1)) code = 8'($urandom_range(255));
          else code = {$urandom_range(1) ? 4'hF : 4'h0, 4'($urandom_range(15))};
          render_cell(code, 8'($urandom_range(255)));
        end
      end
    end
    src_steady = 1'b0;
    snk_steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_store_edges();
    test_attributes();
    test_layouts();
    test_pcg_bank();
    test_random_traffic();
    pause_until_drained();
    repeat (20) @(negedge clk_i);
    $display("Ran %0d glyph writes and %0d cell renders, %0d rows compared,",
             write_cnt, render_cnt, rows_checked);
    $display("over all four layouts, both banks and every attribute bit.");
    if (mism_cnt == 0 && pending_rows_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tcg_pkg.sv
hdl/tcg_seq.sv
hdl/tcg_glyph_mem.sv
hdl/tcg_shade.sv
hdl/text_cell_glyph_row_generator_core.sv
test/tb_text_cell_glyph_row_generator_core.sv
